/* sv/assert_macros.svh */
// assertion helpers for the line tokenizer checker
// expects signals clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked outside reset
`define ILT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer check failed");

// implication in the next cycle, checked outside reset
`define ILT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

// implication in the next cycle, also during reset
`define ILT_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tokenizer check failed");

`endif

/* sv/ilt_pkg.sv */
// types, codes, keyword table and per-byte parse functions
// for the line tokenizer; no dependencies
`default_nettype none

package ilt_pkg;

  localparam int MAX_PARAMS_DEF = 16;
  localparam int KW_COUNT = 15;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_PREFIX  = 3'd1;
  localparam logic [2:0] PH_COMMAND = 3'd2;
  localparam logic [2:0] PH_PARAM   = 3'd3;
  localparam logic [2:0] PH_TRAIL   = 3'd4;

  localparam logic [1:0] KIND_CONTENT = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] FLD_PREFIX  = 2'd0;
  localparam logic [1:0] FLD_COMMAND = 2'd1;
  localparam logic [1:0] FLD_MIDDLE  = 2'd2;
  localparam logic [1:0] FLD_TRAIL   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NO_SPACE  = 2'd2;

  localparam logic [4:0] PCNT_MAX = 5'd16;
  localparam logic [3:0] CLEN_MAX = 4'd8;

  // keywords left aligned, one character per byte from the top
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"PASS", 32'h0}, {"NICK", 32'h0}, {"USER", 32'h0}, {"JOIN", 32'h0},
    {"PART", 32'h0}, {"PRIVMSG", 8'h0}, {"NOTICE", 16'h0}, {"KICK", 32'h0},
    {"INVITE", 16'h0}, {"TOPIC", 24'h0}, {"MODE", 32'h0}, {"QUIT", 32'h0},
    {"PING", 32'h0}, {"PONG", 32'h0}, {"CAP", 40'h0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd4,
    4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3
  };

  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] out_byte;
    logic [1:0] field_kind;
    logic [3:0] param_number;
    logic       field_first;
    logic [1:0] status;
    logic [3:0] param_total;
    logic       param_overflow;
    logic       command_known;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [2:0]          phase;
    logic [4:0]          pcnt;
    logic                started;
    logic [KW_COUNT-1:0] kwm;
    logic [3:0]          clen;
  } state_t;

  typedef struct packed {
    state_t st;
    logic   v;
    item_t  it;
  } step_t;

  // up to three result items caused by one input transaction
  typedef struct packed {
    logic [1:0] cnt;
    item_t [2:0] items;
  } bundle_t;

  localparam state_t STATE_INIT = '{
    phase: PH_START, pcnt: 5'd0, started: 1'b0, kwm: '1, clen: 4'd0
  };

  function automatic logic [4:0] count_up(logic [4:0] p);
    count_up = (p < PCNT_MAX) ? 5'(p + 5'd1) : p;
  endfunction

  function automatic step_t cmd_byte(state_t s, logic [7:0] c);
    step_t r;
    logic [7:0] u;
    r = '0;
    r.st = s;
    u = c;
    if (c == CH_SPACE) begin
      r.st.phase = PH_PARAM;
      r.st.started = 1'b0;
    end else begin
      if (c >= 8'h61 && c <= 8'h7A) u = c - 8'd32;
      for (int k = 0; k < KW_COUNT; k++) begin
        if (s.clen >= KW_LEN[k] || KW_TEXT[k][(7 - s.clen[2:0]) * 8 +: 8] != u)
          r.st.kwm[k] = 1'b0;
      end
      if (s.clen < CLEN_MAX) r.st.clen = 4'(s.clen + 4'd1);
      r.v = 1'b1;
      r.it.item_kind = KIND_CONTENT;
      r.it.out_byte = u;
      r.it.field_kind = FLD_COMMAND;
      r.it.field_first = !s.started;
      r.st.started = 1'b1;
    end
    return r;
  endfunction

  function automatic step_t proc_byte(state_t s, logic [7:0] c, int lim);
    step_t r;
    state_t s2;
    logic [3:0] idx;
    r = '0;
    r.st = s;
    s2 = s;
    idx = (int'(s.pcnt) < lim - 1) ? s.pcnt[3:0] : 4'(lim - 1);
    unique case (s.phase)
      PH_START: begin
        if (c == CH_COLON) begin
          r.st.phase = PH_PREFIX;
          r.st.started = 1'b0;
        end else begin
          s2.started = 1'b0;
          s2.phase = PH_COMMAND;
          r = cmd_byte(s2, c);
        end
      end
      PH_PREFIX: begin
        if (c == CH_SPACE) begin
          r.st.phase = PH_COMMAND;
          r.st.started = 1'b0;
        end else begin
          r.v = 1'b1;
          r.it.item_kind = KIND_CONTENT;
          r.it.out_byte = c;
          r.it.field_kind = FLD_PREFIX;
          r.it.field_first = !s.started;
          r.st.started = 1'b1;
        end
      end
      PH_COMMAND: r = cmd_byte(s, c);
      PH_PARAM: begin
        if (!s.started) begin
          if (c == CH_COLON) begin
            r.st.phase = PH_TRAIL;
          end else if (c == CH_SPACE) begin
            r.v = 1'b1;
            r.it.item_kind = KIND_EMPTY;
            r.it.field_kind = FLD_MIDDLE;
            r.it.param_number = idx;
            r.it.field_first = 1'b1;
            r.st.pcnt = count_up(s.pcnt);
          end else begin
            r.v = 1'b1;
            r.it.item_kind = KIND_CONTENT;
            r.it.out_byte = c;
            r.it.field_kind = FLD_MIDDLE;
            r.it.param_number = idx;
            r.it.field_first = 1'b1;
            r.st.started = 1'b1;
          end
        end else if (c == CH_SPACE) begin
          r.st.pcnt = count_up(s.pcnt);
          r.st.started = 1'b0;
        end else begin
          r.v = 1'b1;
          r.it.item_kind = KIND_CONTENT;
          r.it.out_byte = c;
          r.it.field_kind = FLD_MIDDLE;
          r.it.param_number = idx;
        end
      end
      default: begin
        r.v = 1'b1;
        r.it.item_kind = KIND_CONTENT;
        r.it.out_byte = c;
        r.it.field_kind = FLD_TRAIL;
        r.it.param_number = idx;
        r.it.field_first = !s.started;
        r.st.started = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic item_t summarize(state_t s, int cap);
    item_t it;
    logic [4:0] p;
    it = '0;
    it.item_kind = KIND_SUMMARY;
    it.last = 1'b1;
    p = s.pcnt;
    if (s.phase == PH_START) begin
      it.status = ST_EMPTY;
    end else if (s.phase == PH_PREFIX) begin
      it.status = ST_NO_SPACE;
    end else begin
      if (s.phase == PH_TRAIL || (s.phase == PH_PARAM && s.started))
        p = count_up(s.pcnt);
      it.param_total = (int'(p) > cap) ? 4'(cap) : p[3:0];
      it.param_overflow = (int'(p) > cap);
      for (int k = 0; k < KW_COUNT; k++) begin
        if (s.kwm[k] && KW_LEN[k] == s.clen) it.command_known = 1'b1;
      end
    end
    return it;
  endfunction

endpackage

`default_nettype wire

/* sv/ilt_chan.sv */
// valid/ready channel carrying one payload of type T
// used for both ports of the tokenizer
`default_nettype none

interface ilt_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/ilt_front.sv */
// front end: holds one byte back, runs the parse state and builds
// a bundle of result items per input transaction; uses ilt_pkg
`default_nettype none

module ilt_front import ilt_pkg::*; #(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire in_t     in_data,
  output logic         push_valid,
  input  wire logic    push_ready,
  output bundle_t      push_data
);

  localparam int LIM = (MAX_PARAMS < 16) ? MAX_PARAMS : 16;
  localparam int CAP = (MAX_PARAMS < 15) ? MAX_PARAMS : 15;

  state_t     state, state_next;
  logic [7:0] held_byte;
  logic       held_valid;
  logic       take;

  step_t   a, b;
  state_t  s_mid;
  logic    drop;
  bundle_t bnd;
  logic [1:0] n;

  assign in_ready = push_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    bnd = '0;
    n = 2'd0;
    a = '0;
    b = '0;
    s_mid = state;
    state_next = state;
    drop = held_valid && held_byte == CH_CR && in_data.line_byte == CH_LF;
    if (held_valid && !(in_data.end_of_line && drop)) begin
      a = proc_byte(state, held_byte, LIM);
      s_mid = a.st;
      if (a.v) begin
        bnd.items[n] = a.it;
        n = n + 2'd1;
      end
    end
    if (!in_data.end_of_line) begin
      state_next = s_mid;
    end else begin
      if (!drop) begin
        b = proc_byte(s_mid, in_data.line_byte, LIM);
        s_mid = b.st;
        if (b.v) begin
          bnd.items[n] = b.it;
          n = n + 2'd1;
        end
      end
      bnd.items[n] = summarize(s_mid, CAP);
      n = n + 2'd1;
      state_next = STATE_INIT;
    end
    bnd.cnt = n;
  end

  // empty bundles never enter the queue
  assign push_valid = take && bnd.cnt != 2'd0;
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_INIT;
      held_valid <= 1'b0;
      held_byte <= 8'd0;
    end else if (take) begin
      state <= state_next;
      held_valid <= !in_data.end_of_line;
      held_byte <= in_data.end_of_line ? 8'd0 : in_data.line_byte;
    end
  end

endmodule

`default_nettype wire

/* sv/ilt_fifo.sv */
// two-entry bundle queue between front and back ends
// uses ilt_pkg
`default_nettype none

module ilt_fifo import ilt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push_valid,
  output logic         push_ready,
  input  wire bundle_t push_data,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output bundle_t      pop_data
);

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid = count != 2'd0;
  assign pop_data = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* sv/ilt_back.sv */
// back end: takes bundles from the queue and sends their items
// one per transaction from an output register; uses ilt_pkg
`default_nettype none

module ilt_back import ilt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    pop_valid,
  output logic         pop_ready,
  input  wire bundle_t pop_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output item_t        out_data
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       at_end;

  assign at_end = idx == cur.cnt - 2'd1;
  assign pop_ready = !cur_valid || (out_ready && at_end);
  assign out_valid = cur_valid;
  assign out_data = cur.items[idx];

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur <= pop_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx <= 2'd0;
    end else if (pop_ready) begin
      cur_valid <= pop_valid;
      idx <= 2'd0;
    end else if (out_ready) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

`default_nettype wire

/* sv/irc_line_tokenizer.sv */
// top level of the line tokenizer: front end, bundle queue, back end
// uses ilt_pkg and ilt_chan
//
// One raw byte is taken per cycle, back to back, as long as the two-entry
// queue has room. Each byte yields at most one item, except the byte with
// end_of_line, which yields up to three (the held byte, itself and the
// summary); the back end sends one item per cycle while out_ready is high,
// so after each line the input may stall while the queue drains. Results
// pass through the queue and the back-end output register before they appear.
`default_nettype none

module irc_line_tokenizer import ilt_pkg::*; #(
  parameter int MAX_PARAMS = MAX_PARAMS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ilt_chan.sink    in_ch,
  ilt_chan.source  out_ch
);

  logic    push_valid, push_ready;
  bundle_t push_data;
  logic    pop_valid, pop_ready;
  bundle_t pop_data;
  item_t   out_data;

  ilt_front #(.MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.payload),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  ilt_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
  );

  ilt_back u_back (
    .clk(clk), .rst(rst),
    .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_data)
  );

  assign out_ch.payload = out_data;

endmodule

`default_nettype wire

/* sv/ilt_checker.sv */
// port-level checks for the tokenizer, bound to the top level
// uses ilt_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module ilt_checker import ilt_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire item_t out_data
);

  `ILT_ASSERT_ALWAYS(a_reset_idle, rst, !out_valid)
  `ILT_ASSERT_SAME(a_last_is_summary, out_valid, out_data.last == (out_data.item_kind == KIND_SUMMARY))
  `ILT_ASSERT_SAME(a_bad_status_zero, out_valid && out_data.last && out_data.status != ST_OK, out_data.param_total == 4'd0 && !out_data.command_known)
  `ILT_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind irc_line_tokenizer ilt_checker u_checker (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.payload)
);

`default_nettype wire
